// ----- rtl/core/htqp_pkg.sv -----
// ----------------------------------------------------------------------------
// htqp_pkg: shared types and constants of the quadratic probe hash table.
// Holds command and status codes and the queue entry passed front to back.
// ----------------------------------------------------------------------------
package htqp_pkg;

   localparam int DefTableSize   = 1543;
   localparam int DefMaxKeyBytes = 8;

   typedef enum logic [2:0] {
      CMD_INSERT   = 3'd0,
      CMD_CONTAINS = 3'd1,
      CMD_GET      = 3'd2,
      CMD_SET      = 3'd3,
      CMD_REMOVE   = 3'd4
   } cmd_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   // One classified command as it waits between front and back.
   typedef struct packed {
      logic [2:0]  command;
      logic [63:0] key;
      logic [3:0]  len;
      logic [31:0] value;
      logic [31:0] hash;
   } entry_type;

endpackage

// ----- rtl/core/htqp_front.sv -----
// ----------------------------------------------------------------------------
// htqp_front: key masking and hash computation.
// Masks the key to its length, runs Horner's rule one byte per cycle and
// pushes the finished entry to the queue.
// ----------------------------------------------------------------------------
module htqp_front
   import htqp_pkg::*;
#(
   parameter int MaxKeyBytes = DefMaxKeyBytes
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               front_busy,
   input  logic [2:0]         req_command,
   input  logic [63:0]        req_key_bytes,
   input  logic [3:0]         req_key_length,
   input  logic [31:0]        req_value_in,
   output logic               push,
   output htqp_pkg::entry_type push_entry,
   input  logic               queue_full
);
   localparam logic [3:0] MaxLen = 4'(MaxKeyBytes);

   logic        active_ff, active_in;
   logic        done_ff, done_in;
   entry_type   ent_ff, ent_in;
   logic [3:0]  idx_ff, idx_in;
   logic [3:0]  len_sat;
   logic [63:0] mask;
   logic [7:0]  byte_cur;

   always_comb begin
      len_sat = (req_key_length > MaxLen) ? MaxLen : req_key_length;
      mask    = (len_sat >= 4'd8) ? '1 : ((64'd1 << {len_sat, 3'b000}) - 64'd1);
   end

   assign byte_cur   = ent_ff.key[{idx_ff[2:0], 3'b000} +: 8];
   assign front_busy = active_ff;
   assign push       = done_ff && !queue_full;
   assign push_entry = ent_ff;

   // Accept, then hash one byte per cycle, then wait for queue room.
   always_comb begin
      active_in = active_ff;
      done_in   = done_ff;
      ent_in    = ent_ff;
      idx_in    = idx_ff;
      if (!active_ff && start) begin
         active_in     = 1'b1;
         done_in       = (len_sat == 4'd0);
         ent_in.command = req_command;
         ent_in.key     = req_key_bytes & mask;
         ent_in.len     = len_sat;
         ent_in.value   = req_value_in;
         ent_in.hash    = '0;
         idx_in         = '0;
      end else if (active_ff && !done_ff) begin
         ent_in.hash = ent_ff.hash * 32'd37 + {{24{byte_cur[7]}}, byte_cur};
         idx_in      = idx_ff + 4'd1;
         done_in     = (idx_ff + 4'd1 == ent_ff.len);
      end else if (push) begin
         active_in = 1'b0;
         done_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      ent_ff <= ent_in;
      idx_ff <= idx_in;
   end

endmodule

// ----- rtl/core/htqp_queue.sv -----
// ----------------------------------------------------------------------------
// htqp_queue: two-entry queue between the hashing front and the probe back.
// ----------------------------------------------------------------------------
module htqp_queue
   import htqp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  htqp_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output htqp_pkg::entry_type head
);
   entry_type  mem_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == 2'd2);
   assign not_empty = (cnt_ff != 2'd0);
   assign head      = mem_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   // Pointer and count update; storage needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_entry;
   end

endmodule

// ----- rtl/core/htqp_back.sv -----
// ----------------------------------------------------------------------------
// htqp_back: probe engine and slot store.
// Reduces the hash modulo the table size, walks probe slots one memory read
// per step, and applies the command's update to the found slot.
// ----------------------------------------------------------------------------
module htqp_back
   import htqp_pkg::*;
#(
   parameter int TableSize = DefTableSize
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               not_empty,
   input  htqp_pkg::entry_type head,
   output logic               pop,
   output logic               back_busy,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic               rsp_found,
   output logic [31:0]        rsp_value_out
);
   localparam int AW = $clog2(TableSize);
   localparam int CW = $clog2(TableSize + 1);
   localparam logic [AW:0]  TsW  = (AW + 1)'(TableSize);
   localparam logic [31:0]  Ts32 = 32'(TableSize);
   // Truncated reciprocal of the table size, scaled by 2^32.
   localparam logic [31:0]  Recip = 32'(64'h1_0000_0000 / 64'(TableSize));
   localparam logic [CW-1:0] HalfT = CW'(TableSize / 2);
   localparam logic [CW-1:0] TsC  = CW'(TableSize);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_MOD   = 6'b000010,
      S_READ  = 6'b000100,
      S_CHECK = 6'b001000,
      S_EXEC  = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   // Slot store: payload in memories, flags in memories cleared after reset.
   logic [99:0] slot_mem [TableSize];
   logic [1:0]  flag_mem [TableSize];

   state_type    state_ff, state_in;
   entry_type    cur_ff;
   logic [63:0]  prod_ff;
   logic [31:0]  qts_ff;
   logic [1:0]   step_ff;
   logic [AW-1:0] pos_ff;
   logic [AW-1:0] off_ff;
   logic [CW-1:0] n_ff;
   logic [CW-1:0] fill_ff;
   logic          hit_ff;
   logic [99:0]   rd_slot_ff;
   logic [1:0]    rd_flag_ff;
   logic          clr_ff;
   logic [AW-1:0] clr_addr_ff;
   logic [1:0]    status_ff;
   logic          found_ff;
   logic [31:0]   vout_ff;

   logic          occ, del, match, live;
   logic [AW:0]   pos_sum, off_sum;
   logic [31:0]   mag, red, red_fix;

   assign occ   = rd_flag_ff[0];
   assign del   = rd_flag_ff[1];
   assign match = occ && (rd_slot_ff[99:36] == cur_ff.key) && (rd_slot_ff[35:32] == cur_ff.len);
   assign live  = hit_ff && occ && !del;
   assign pop   = (state_ff == S_IDLE) && not_empty && !clr_ff;
   assign back_busy = (state_ff != S_IDLE) || clr_ff;
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_status = status_ff;
   assign rsp_found  = found_ff;
   assign rsp_value_out = vout_ff;

   assign pos_sum = {1'b0, pos_ff} + {1'b0, off_ff};
   assign off_sum = {1'b0, off_ff} + (AW + 1)'(2);

   // Magnitude of the signed hash and its remainder from the estimated quotient.
   // The estimate is low by at most one, so one subtraction finishes it.
   assign mag     = cur_ff.hash[31] ? (32'd0 - cur_ff.hash) : cur_ff.hash;
   assign red     = mag - qts_ff;
   assign red_fix = (red >= Ts32) ? (red - Ts32) : red;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (pop) state_in = S_MOD;
         S_MOD:   if (step_ff == 2'd0) state_in = S_READ;
         S_READ:  state_in = S_CHECK;
         S_CHECK: begin
            if (!occ || match || n_ff == TsC - CW'(1)) state_in = S_EXEC;
            else state_in = S_READ;
         end
         S_EXEC:  state_in = S_RESP;
         S_RESP:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         fill_ff     <= '0;
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (clr_ff) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(TableSize - 1)) clr_ff <= 1'b0;
         end
         if (state_ff == S_EXEC && cur_ff.command == CMD_INSERT && hit_ff && !occ
             && fill_ff < HalfT)
            fill_ff <= fill_ff + CW'(1);
      end
   end

   // Datapath: reciprocal signed modulo, probe walk, command execution.
   always_ff @(posedge clock) begin
      if (clr_ff) flag_mem[clr_addr_ff] <= 2'b00;
      unique case (state_ff)
         S_IDLE: begin
            cur_ff  <= head;
            step_ff <= 2'd2;
         end
         S_MOD: begin
            // Quotient estimate, then its multiple, then the home slot.
            if (step_ff == 2'd2) begin
               prod_ff <= 64'(mag) * 64'(Recip);
               step_ff <= 2'd1;
            end else if (step_ff == 2'd1) begin
               qts_ff  <= 32'(prod_ff[63:32] * Ts32);
               step_ff <= 2'd0;
            end else begin
               if (cur_ff.hash[31] && red_fix != '0)
                  pos_ff <= AW'(Ts32 - red_fix);
               else
                  pos_ff <= AW'(red_fix);
               off_ff <= AW'(1);
               n_ff   <= '0;
            end
         end
         S_READ: begin
            rd_slot_ff <= slot_mem[pos_ff];
            rd_flag_ff <= flag_mem[pos_ff];
         end
         S_CHECK: begin
            hit_ff <= !occ || match;
            if (occ && !match) begin
               pos_ff <= (pos_sum >= TsW) ? AW'(pos_sum - TsW) : AW'(pos_sum);
               off_ff <= (off_sum >= TsW) ? AW'(off_sum - TsW) : AW'(off_sum);
               n_ff   <= n_ff + CW'(1);
            end
         end
         S_EXEC: begin
            status_ff <= ST_NOTFOUND;
            found_ff  <= 1'b0;
            vout_ff   <= '0;
            case (cur_ff.command)
               CMD_INSERT: begin
                  found_ff <= live;
                  if (!hit_ff) status_ff <= ST_FULL;
                  else if (occ) begin
                     slot_mem[pos_ff] <= {rd_slot_ff[99:32], cur_ff.value};
                     flag_mem[pos_ff] <= 2'b01;
                     status_ff <= ST_OK;
                  end else if (fill_ff >= HalfT) status_ff <= ST_FULL;
                  else begin
                     slot_mem[pos_ff] <= {cur_ff.key, cur_ff.len, cur_ff.value};
                     flag_mem[pos_ff] <= 2'b01;
                     status_ff <= ST_OK;
                  end
               end
               CMD_CONTAINS: begin
                  found_ff <= live;
                  if (live) status_ff <= ST_OK;
               end
               CMD_GET: begin
                  found_ff <= live;
                  if (live) begin
                     status_ff <= ST_OK;
                     vout_ff   <= rd_slot_ff[31:0];
                  end
               end
               CMD_SET: begin
                  found_ff <= live;
                  if (live) begin
                     status_ff <= ST_OK;
                     slot_mem[pos_ff] <= {rd_slot_ff[99:32], cur_ff.value};
                  end
               end
               CMD_REMOVE: begin
                  found_ff <= live;
                  if (live) begin
                     status_ff <= ST_OK;
                     flag_mem[pos_ff] <= 2'b11;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

endmodule

// ----- rtl/core/hash_table_quadratic_probe_unit.sv -----
// ----------------------------------------------------------------------------
// hash_table_quadratic_probe_unit: open-addressing hash table, quadratic probe.
//
// Commands enter on the req_ ports when start is high and busy is low; each
// command gives exactly one result beat, shown for one cycle with rsp_valid.
// The receiver cannot stall: a result is taken in the cycle it is shown.
// The front hashes the key one byte per cycle and hands it through a
// two-entry queue to the back, which reduces the hash by reciprocal
// multiplication (quotient estimate, its multiple, home slot), then probes
// each visited slot with one memory read and one compare, then applies the
// update and shows the result. The back takes a new command from the queue
// only when it is idle, after the result of the earlier one.
// busy stays high while the front hashes the key and until the entry is
// pushed, and longer while the queue is full, so the front can hash the
// next command while the back still works on the earlier one.
// After reset the slot flags are cleared in a pass over all TableSize slots;
// the back takes no queued command until that pass is done.
// ----------------------------------------------------------------------------
module hash_table_quadratic_probe_unit
   import htqp_pkg::*;
#(
   parameter int TableSize   = DefTableSize,
   parameter int MaxKeyBytes = DefMaxKeyBytes
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [63:0] req_key_bytes,
   input  logic [3:0]  req_key_length,
   input  logic [31:0] req_value_in,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic        rsp_found,
   output logic [31:0] rsp_value_out
);
   logic      push, queue_full, pop, not_empty, back_busy;
   entry_type push_entry, head;

   htqp_front #(.MaxKeyBytes(MaxKeyBytes)) u_front (
      .clock, .reset, .start, .front_busy(busy),
      .req_command, .req_key_bytes, .req_key_length, .req_value_in,
      .push, .push_entry, .queue_full
   );

   htqp_queue u_queue (
      .clock, .reset, .push, .push_entry, .full(queue_full),
      .pop, .not_empty, .head
   );

   htqp_back #(.TableSize(TableSize)) u_back (
      .clock, .reset, .not_empty, .head, .pop, .back_busy,
      .rsp_valid, .rsp_status, .rsp_found, .rsp_value_out
   );

   // Status codes stay within the defined set.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 2'd3)) else $error("bad status code");
   // A returned value implies a live key.
   a_value_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_value_out != '0 |-> rsp_found) else $error("value without hit");
   // A result is a single beat.
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result repeated");
   // Results appear only while the back is working.
   a_back_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> back_busy) else $error("result while idle");

endmodule

// ----- tb/hash_table_quadratic_probe_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for hash_table_quadratic_probe_unit.
// A short directed table, then random command streams over a small key pool,
// are sent to the table. A software copy of the open-addressing table
// predicts every result beat not typed in by hand, and each beat is compared field by field.
// ----------------------------------------------------------------------------
module hash_table_quadratic_probe_unit_tb;
   import htqp_pkg::*;

   localparam int Slots    = DefTableSize;
   localparam int KeyMax   = DefMaxKeyBytes;
   localparam int PoolSize = 48;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_command = '0;
   logic [63:0] req_key_bytes = '0;
   logic [3:0]  req_key_length = 4'd1;
   logic [31:0] req_value_in = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic        rsp_found;
   logic [31:0] rsp_value_out;

   typedef struct packed {
      logic [1:0]  status;
      logic        found;
      logic [31:0] value;
   } answer_type;

   typedef struct {
      logic [2:0]  command;
      logic [63:0] key;
      logic [3:0]  len;
      logic [31:0] value;
      bit          typed;
      answer_type  answer;
   } row_type;

   // Software copy of the table.
   logic [63:0] tbl_key [Slots];
   logic [3:0]  tbl_len [Slots];
   logic [31:0] tbl_val [Slots];
   bit          tbl_used [Slots];
   bit          tbl_gone [Slots];
   int          tbl_fill;

   answer_type  pending_answers[$];
   logic [63:0] key_pool [PoolSize];
   int          errors = 0;
   int          send_gap_pct = 8;

   hash_table_quadratic_probe_unit dut (.*);

   always #4 clock = ~clock;

   initial begin
      #50ms;
      $display("** hash_table_quadratic_probe_unit: FAILED **");
      $finish;
   end

   // Horner hash over signed bytes, reduced into 0..Slots-1.
   function automatic int home_slot(logic [63:0] key, int len);
      logic signed [31:0] h;
      longint r;
      h = 0;
      for (int i = 0; i < len; i++)
         h = h * 37 + {{24{key[8*i+7]}}, key[8*i +: 8]};
      r = longint'(h) % Slots;
      if (r < 0) r += Slots;
      return int'(r);
   endfunction

   // Works out one command's result and updates the software table.
   function automatic answer_type table_apply(logic [2:0] command, logic [63:0] key,
                                             logic [3:0] len_in, logic [31:0] value);
      answer_type a;
      int len, pos, off;
      bit hit, live;
      len = (len_in > KeyMax) ? KeyMax : len_in;
      if (len < 8) key &= (64'd1 << (8 * len)) - 64'd1;
      pos = home_slot(key, len);
      off = 1;
      hit = 1'b0;
      for (int n = 0; n < Slots && !hit; n++) begin
         if (!tbl_used[pos] || (tbl_key[pos] == key && tbl_len[pos] == len)) begin
            hit = 1'b1;
         end else begin
            pos = (pos + off) % Slots;
            off = (off + 2) % Slots;
         end
      end
      live = hit && tbl_used[pos] && !tbl_gone[pos];
      a = '{status: ST_NOTFOUND, found: live, value: '0};
      case (command)
         CMD_INSERT: begin
            if (!hit) a.status = ST_FULL;
            else if (tbl_used[pos]) begin
               tbl_val[pos] = value;
               tbl_gone[pos] = 1'b0;
               a.status = ST_OK;
            end else if (tbl_fill + 1 > Slots / 2) a.status = ST_FULL;
            else begin
               tbl_key[pos] = key;
               tbl_len[pos] = 4'(len);
               tbl_val[pos] = value;
               tbl_used[pos] = 1'b1;
               tbl_gone[pos] = 1'b0;
               tbl_fill++;
               a.status = ST_OK;
            end
         end
         CMD_CONTAINS: if (live) a.status = ST_OK;
         CMD_GET: if (live) begin
            a.value = tbl_val[pos];
            a.status = ST_OK;
         end
         CMD_SET: if (live) begin
            tbl_val[pos] = value;
            a.status = ST_OK;
         end
         CMD_REMOVE: if (live) begin
            tbl_gone[pos] = 1'b1;
            a.status = ST_OK;
         end
         default: a.found = 1'b0;
      endcase
      return a;
   endfunction

   // Sends one command beat and queues its expected result.
   // start stays high between beats that follow with no gap.
   task automatic send_beat(logic [2:0] command, logic [63:0] key, logic [3:0] len,
                            logic [31:0] value, bit typed, answer_type typed_answer);
      answer_type a;
      if ($urandom_range(99) < send_gap_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      start <= 1'b1;
      req_command <= command;
      req_key_bytes <= key;
      req_key_length <= len;
      req_value_in <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      a = table_apply(command, key, len, value);
      pending_answers.push_back(typed ? typed_answer : a);
   endtask

   // Stops sending and waits until every expected result has come.
   task automatic drain();
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   // Check every result beat against the oldest expectation.
   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected result beat");
            errors++;
         end else begin
            e = pending_answers.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, actual %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_found !== e.found) begin
               $error("found: expected %0d, actual %0d", e.found, rsp_found);
               errors++;
            end
            if (rsp_value_out !== e.value) begin
               $error("value_out: expected %h, actual %h", e.value, rsp_value_out);
               errors++;
            end
         end
      end
   end

   function automatic logic [63:0] rand_key();
      return {$urandom(), $urandom()};
   endfunction

   task automatic random_phase(int count);
      logic [2:0] command;
      logic [63:0] key;
      logic [3:0] len;
      int k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(99);
         if (k < 85) begin
            // Well-formed traffic over a small key pool so keys recur.
            key = key_pool[$urandom_range(PoolSize - 1)];
            command = 3'($urandom_range(4));
            len = 4'(1 + (key[63:60] % 8));
         end else begin
            key = rand_key();
            command = 3'($urandom_range(7));
            len = 4'($urandom_range(15));
         end
         send_beat(command, key, len, $urandom(), 1'b0, '0);
      end
   endtask

   initial begin
      row_type rows[$];
      logic [63:0] fill_key;
      for (int i = 0; i < Slots; i++) begin
         tbl_used[i] = 1'b0;
         tbl_gone[i] = 1'b0;
         tbl_key[i] = '0;
         tbl_len[i] = '0;
         tbl_val[i] = '0;
      end
      tbl_fill = 0;
      for (int i = 0; i < PoolSize; i++) key_pool[i] = rand_key();

      // Directed rows; expected result typed in where obvious.
      rows = '{
         '{CMD_CONTAINS, 64'h41, 4'd1, 32'h0, 1, '{ST_NOTFOUND, 1'b0, 32'h0}},
         '{CMD_GET, 64'h41, 4'd1, 32'h0, 1, '{ST_NOTFOUND, 1'b0, 32'h0}},
         '{CMD_SET, 64'h41, 4'd1, 32'h5, 1, '{ST_NOTFOUND, 1'b0, 32'h0}},
         '{CMD_REMOVE, 64'h41, 4'd1, 32'h0, 1, '{ST_NOTFOUND, 1'b0, 32'h0}},
         '{CMD_INSERT, 64'h41, 4'd1, 32'hFFFFFFFF, 1, '{ST_OK, 1'b0, 32'h0}},
         '{CMD_GET, 64'h41, 4'd1, 32'h0, 1, '{ST_OK, 1'b1, 32'hFFFFFFFF}},
         '{CMD_INSERT, '1, 4'd8, 32'h0, 0, '0},
         '{CMD_GET, '1, 4'd15, 32'h0, 0, '0},
         '{CMD_INSERT, 64'h0, 4'd0, 32'h1234, 0, '0},
         '{CMD_GET, 64'hFF00, 4'd0, 32'h0, 0, '0},
         '{CMD_INSERT, 64'h8080808080808080, 4'd8, 32'hA5A5A5A5, 0, '0},
         '{CMD_SET, 64'h8080808080808080, 4'd8, 32'h5A5A5A5A, 0, '0},
         '{CMD_GET, 64'h8080808080808080, 4'd9, 32'h0, 0, '0},
         '{CMD_GET, 64'hDEAD41, 4'd1, 32'h0, 0, '0},
         '{CMD_REMOVE, 64'h41, 4'd1, 32'h0, 1, '{ST_OK, 1'b1, 32'h0}},
         '{CMD_CONTAINS, 64'h41, 4'd1, 32'h0, 1, '{ST_NOTFOUND, 1'b0, 32'h0}},
         '{CMD_GET, 64'h41, 4'd1, 32'h0, 1, '{ST_NOTFOUND, 1'b0, 32'h0}},
         '{CMD_INSERT, 64'h41, 4'd1, 32'h77, 1, '{ST_OK, 1'b0, 32'h0}},
         '{CMD_GET, 64'h41, 4'd1, 32'h0, 1, '{ST_OK, 1'b1, 32'h77}},
         '{3'd5, 64'h41, 4'd1, 32'h0, 1, '{ST_NOTFOUND, 1'b0, 32'h0}},
         '{3'd7, '1, 4'd8, '1, 1, '{ST_NOTFOUND, 1'b0, 32'h0}},
         '{CMD_INSERT, 64'h7F7F7F7F7F7F7F7F, 4'd8, 32'h1, 0, '0},
         '{CMD_CONTAINS, 64'h7F7F7F7F7F7F7F7F, 4'd7, 32'h0, 0, '0}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i])
         send_beat(rows[i].command, rows[i].key, rows[i].len, rows[i].value,
                   rows[i].typed, rows[i].answer);

      // Hold off until the table has answered everything.
      drain();

      send_gap_pct = 8;
      random_phase(200);
      send_gap_pct = 67;
      random_phase(150);
      send_gap_pct = 0;
      random_phase(150);

      // Fill the table to half load, then insert more to reach the full status.
      while (tbl_fill < Slots / 2) begin
         fill_key = rand_key();
         send_beat(CMD_INSERT, fill_key, 4'd8, $urandom(), 1'b0, '0);
      end
      for (int i = 0; i < 20; i++)
         send_beat(CMD_INSERT, rand_key(), 4'($urandom_range(1, 8)), $urandom(), 1'b0, '0);
      random_phase(80);

      drain();
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("** hash_table_quadratic_probe_unit: PASSED **");
      else
         $display("** hash_table_quadratic_probe_unit: FAILED **");
      $finish;
   end

endmodule
